>>> rtl/lres_pkg.sv
package lres_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int TARGET_RATE_DEF = 48000;

  // Configuration register map
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b1;

  localparam int RATE_W       = 18;
  localparam int FRAMES_W     = 24;
  localparam int RATE_MIN     = 8000;
  localparam int RATE_MAX     = 192000;
  localparam int RATE_RESET   = 48000;
  localparam int FRAMES_RESET = 1;

  localparam int ACC_W       = 48;
  localparam int MAX_RESULTS = 13;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic accept;     // take the input item and set up the step
    logic mul_frac;   // phase -> 16-bit fraction
    logic mul_blend;  // (V1 - V0) * fraction
    logic emit;       // load the result register, advance counters
    logic adjust;     // wrap phase, advance frame count
    logic tail;       // held-sample outputs at clip end
  } lres_cmd_t;

  typedef struct packed {
    logic first;      // no frame taken yet in this clip
    logic entry_go;   // an interpolated output is owed at step start
    logic out_free;   // result register can take a new item
    logic more;       // another output follows the one being emitted
    logic loop_more;  // another interpolated output follows
    logic tail_go;    // a held output is owed after the adjust
    logic last;       // this step ends the clip
  } lres_sts_t;

endpackage

>>> rtl/lres_ctrl.sv
module lres_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  lres_pkg::lres_sts_t sts,
  output lres_pkg::lres_cmd_t cmd
);
  import lres_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_ADJ  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       tail_r, tail_nxt;

  always_comb begin
    cmd       = '0;
    cmd.tail  = tail_r;
    in_tready = 1'b0;
    state_nxt = state_r;
    tail_nxt  = tail_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          tail_nxt   = 1'b0;
          state_nxt  = (!sts.first && sts.entry_go) ? ST_MUL1 : ST_ADJ;
        end
      end
      ST_MUL1: begin
        cmd.mul_frac = 1'b1;
        state_nxt    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_blend = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the result register drains
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (tail_r) begin
            state_nxt = sts.more ? ST_EMIT : ST_IDLE;
          end else begin
            state_nxt = sts.loop_more ? ST_MUL1 : ST_ADJ;
          end
        end
      end
      ST_ADJ: begin
        cmd.adjust = 1'b1;
        if (sts.last && sts.tail_go) begin
          tail_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tail_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tail_r  <= tail_nxt;
    end
  end

endmodule

>>> rtl/lres_datapath.sv
module lres_datapath #(
  parameter int SAMPLE_BITS = lres_pkg::SAMPLE_BITS_DEF,
  parameter int TARGET_RATE = lres_pkg::TARGET_RATE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wen,
  input  logic [lres_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lres_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample,
  input  lres_pkg::lres_cmd_t            cmd,
  output lres_pkg::lres_sts_t            sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]  out_sample,
  output logic                          out_run_last,
  output logic                          out_clip_last
);
  import lres_pkg::*;

  // frac16 = floor(phase * 2^16 / TARGET_RATE) as phase * FRAC_M >> FRAC_S;
  // exact for phase < TARGET_RATE since 2^FRAC_S >= TARGET_RATE^2
  localparam int          TR_BITS = $clog2(TARGET_RATE);
  localparam int          FRAC_S  = 2 * TR_BITS;
  localparam logic [63:0] FRAC_M  =
    ((64'd1 << (16 + FRAC_S)) + 64'(TARGET_RATE) - 64'd1) / 64'(TARGET_RATE);
  localparam int          M_W     = $clog2(FRAC_M + 64'd1);
  localparam int          PH_W    = $clog2(TARGET_RATE + RATE_MAX);
  localparam int          P1_W    = PH_W + M_W;
  localparam int          P2_W    = SAMPLE_BITS + 18;
  localparam int          TT_W    = $clog2(2 * TARGET_RATE + 1);
  localparam int          LP_W    = FRAMES_W + TT_W;

  // configuration, kept in the form the step uses
  logic [RATE_W-1:0]   rate_r, rate_raw, rate_clamp;
  logic [FRAMES_W-1:0] frames_r, frames_raw, frames_clamp;
  logic [ACC_W-1:0]    limit_r;
  logic [LP_W-1:0]     lim_prod;

  // step state
  logic signed [SAMPLE_BITS-1:0] sample_r, prev_r;
  logic                          last_r;
  logic [PH_W-1:0]               phase_r;
  logic [FRAMES_W-1:0]           seen_r;
  logic [ACC_W-1:0]              acc_r;
  logic [CNT_W-1:0]              n_r;
  logic [P1_W-1:0]               p1_r;
  logic signed [P2_W-1:0]        p2_r;
  logic                          out_valid_r, out_run_r, out_clip_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;

  logic                          first, last_in, phase_lt, emit_ok, more_any, loop_more;
  logic [FRAMES_W:0]             seen_inc;
  logic [ACC_W-1:0]              acc_nxt;
  logic [PH_W-1:0]               phase_nxt, phase_adj;
  logic [CNT_W-1:0]              n_nxt;
  logic [15:0]                   frac;
  logic [P1_W-1:0]               p1_nxt;
  logic signed [P2_W-1:0]        diff, frac_ext, p2_nxt;
  logic signed [SAMPLE_BITS-1:0] interp;

  always_comb begin
    rate_raw = cfg_wdata[RATE_W-1:0];
    if (rate_raw < RATE_W'(RATE_MIN)) begin
      rate_clamp = RATE_W'(RATE_MIN);
    end else if (rate_raw > RATE_W'(RATE_MAX)) begin
      rate_clamp = RATE_W'(RATE_MAX);
    end else begin
      rate_clamp = rate_raw;
    end
    frames_raw   = cfg_wdata[FRAMES_W-1:0];
    frames_clamp = (frames_raw == '0) ? FRAMES_W'(1) : frames_raw;
    lim_prod     = LP_W'(frames_clamp) * LP_W'(2 * TARGET_RATE);
  end

  always_comb begin
    first     = (seen_r == '0);
    seen_inc  = {1'b0, seen_r} + (FRAMES_W + 1)'(1);
    last_in   = (seen_inc >= {1'b0, frames_r});
    phase_lt  = (phase_r < PH_W'(TARGET_RATE));
    phase_adj = phase_lt ? '0 : phase_r - PH_W'(TARGET_RATE);

    acc_nxt   = acc_r + ACC_W'({rate_r, 1'b0});
    phase_nxt = cmd.tail ? phase_r : phase_r + PH_W'(rate_r);
    n_nxt     = n_r + CNT_W'(1);
    emit_ok   = (n_nxt < CNT_W'(MAX_RESULTS)) && (acc_nxt <= limit_r);
    loop_more = emit_ok && (phase_nxt < PH_W'(TARGET_RATE));
    more_any  = loop_more || (emit_ok && last_r);

    p1_nxt   = P1_W'(phase_r) * P1_W'(FRAC_M[M_W-1:0]);
    frac     = p1_r[FRAC_S +: 16];
    diff     = P2_W'(sample_r) - P2_W'(prev_r);
    frac_ext = {{(P2_W - 16){1'b0}}, frac};
    p2_nxt   = diff * frac_ext;
    interp   = prev_r + SAMPLE_BITS'(p2_r >>> 16);

    sts.first     = first;
    sts.entry_go  = phase_lt && (acc_r <= limit_r);
    sts.out_free  = !out_valid_r || out_ready;
    sts.more      = more_any;
    sts.loop_more = loop_more;
    sts.tail_go   = (n_r < CNT_W'(MAX_RESULTS)) && (acc_r <= limit_r);
    sts.last      = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= RATE_W'(RATE_RESET);
      frames_r <= FRAMES_W'(FRAMES_RESET);
      limit_r  <= ACC_W'(2 * TARGET_RATE * FRAMES_RESET);
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_SOURCE_RATE: begin
          rate_r <= rate_clamp;
        end
        CFG_FRAME_COUNT: begin
          frames_r <= frames_clamp;
          limit_r  <= ACC_W'(lim_prod);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      last_r      <= 1'b0;
      phase_r     <= '0;
      seen_r      <= '0;
      acc_r       <= ACC_W'(RATE_RESET);
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        last_r <= last_in;
        n_r    <= '0;
        // first frame of a clip: restart phase and output count check
        if (first) begin
          phase_r <= '0;
          acc_r   <= ACC_W'(rate_r);
        end
      end
      if (cmd.emit) begin
        acc_r   <= acc_nxt;
        phase_r <= phase_nxt;
        n_r     <= n_nxt;
      end
      if (cmd.adjust) begin
        prev_r <= sample_r;
        if (last_r) begin
          phase_r <= '0;
          seen_r  <= '0;
        end else begin
          phase_r <= phase_adj;
          seen_r  <= seen_r + FRAMES_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample;
    end
    if (cmd.mul_frac) begin
      p1_r <= p1_nxt;
    end
    if (cmd.mul_blend) begin
      p2_r <= p2_nxt;
    end
    if (cmd.emit) begin
      out_sample_r <= cmd.tail ? sample_r : interp;
      out_run_r    <= !more_any;
      out_clip_r   <= (acc_nxt > limit_r) || (last_r && !more_any);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_run_last  = out_run_r;
  assign out_clip_last = out_clip_r;

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while full");

  a_clip_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_clip_r) |-> out_run_r)
    else $error("clip end not flagged as end of run");

  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.adjust |=> (phase_r < PH_W'(RATE_MAX)))
    else $error("phase left out of range after adjust");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_RESULTS))
    else $error("per-item output count above cap");
`endif

endmodule

>>> rtl/linear_resampler_to_48k_top.sv
// Channel  Direction  tdata                     tuser      tlast
// in_      slave      sample_in                 -          -
// out_     master     sample_out                clip_last  run_last
// cfg_     write      index 0 source_rate, index 1 frame_count
//
// An item runs accept, then for each interpolated output a fraction multiply, a blend
// multiply and a result load, then one phase adjust, and at clip end one result load per
// held output; an item gives at most 6 interpolated outputs from an 8 kHz source.
// The fraction and blend multipliers run in sequence on one output at a time.
// Reset is synchronous; it clears the clip counters and sets 48000 Hz, 1 frame.
// out_tready low holds the result register and stalls the next output load;
// in_tready is high between items, also while a result waits to be taken.
module linear_resampler_to_48k_top #(
  parameter int SAMPLE_BITS = lres_pkg::SAMPLE_BITS_DEF,
  parameter int TARGET_RATE = lres_pkg::TARGET_RATE_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wen,
  input  logic [lres_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [lres_pkg::CFG_W-1:0]              cfg_wdata,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,   // sample_in
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] out_tdata,  // sample_out
  output logic                                    out_tuser,  // clip_last
  output logic                                    out_tlast   // run_last
);
  import lres_pkg::*;

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  lres_cmd_t                     cmd;
  lres_sts_t                     sts;
  logic signed [SAMPLE_BITS-1:0] in_sample, out_sample;

  assign in_sample = $signed(in_tdata[SAMPLE_BITS-1:0]);
  assign out_tdata = TDATA_W'($unsigned(out_sample));

  lres_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lres_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TARGET_RATE (TARGET_RATE)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_sample     (in_sample),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_sample    (out_sample),
    .out_run_last  (out_tlast),
    .out_clip_last (out_tuser)
  );

endmodule
